/* sv/first_fit_heap_allocator_unit_defines.svh */
// Assertion helpers shared by the checker file.
// Both macros expect clk_i and rst_ni to be visible where they are used.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define FFHA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffha checker: same-cycle property failed");

// Next-cycle implication.
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffha checker: next-cycle property failed");

`endif

/* sv/ffha_pkg.sv */
package ffha_pkg;

  // Result status codes.
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusNoSpace = 2'd1;
  localparam logic [1:0] StatusBadFree = 2'd2;

  // Request type codes.
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_size;
    logic [15:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
    logic [5:0]  block_total;
  } rsp_t;

  // One row of the block table.
  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] length;
    logic        is_free;
  } entry_t;

endpackage

/* sv/ffha_ram.sv */
module ffha_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator. The unit keeps an address-ordered table of up to
// MAX_BLOCKS heap blocks in a single RAM, each row holding the header offset,
// the payload length and a free mark; every payload sits HEADER_BYTES behind
// its header. An allocate takes the first free block that is large enough,
// splitting off the rest as a new free block when the rest can hold a header
// and the table has room, and otherwise appends a new block at the heap end.
// A free marks the block with the given payload address as free; free blocks
// are never merged. Every request gives exactly one result with the payload
// address (zero for a free or an error), a status and the table size after
// the request. The unit handles one request at a time and holds in_stall_o
// high until its result is loaded into the output register. The table is
// walked through one RAM read port with a registered read, one row per cycle,
// and all address and size arithmetic goes through one shared 18-bit adder.
// A split moves every row above the chosen one up by one. A request that
// finds no row reads the whole table before it appends or fails. The
// slowest request is a split in a table of MAX_BLOCKS - 1 rows; a result
// that waits on a stalled output is held back further.
// The table needs no clearing after reset: only rows below the block count
// are ever used, so a request can be accepted in the first cycle after reset.
module first_fit_heap_allocator_unit #(
  parameter int unsigned MAX_BLOCKS   = 32,
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned HEADER_BYTES = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ffha_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ffha_pkg::rsp_t out_rsp_o
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned EntW = $bits(ffha_pkg::entry_t);
  localparam logic [17:0] Hdr      = 18'(HEADER_BYTES);
  localparam logic [17:0] HeapLim  = 18'(HEAP_BYTES);
  localparam logic [17:0] AddrLim  = 18'(65535);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_TAKE,
    S_TEST,
    S_SHIFT,
    S_NEWO,
    S_CUR,
    S_APP,
    S_APP2,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  ffha_pkg::req_t   req_q, req_d;
  ffha_pkg::entry_t ent_q, ent_d;
  ffha_pkg::rsp_t   out_q, out_d;
  logic             out_vld_q, out_vld_d;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [16:0]     heap_end_q, heap_end_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] p_idx_q, p_idx_d;
  logic            pv_q, pv_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] j_q, j_d;
  logic [IdxW-1:0] wj_q, wj_d;
  logic [15:0]     rest_q, rest_d;
  logic [15:0]     pay_q, pay_d;
  logic [15:0]     newlen_q, newlen_d;
  logic [17:0]     acc_q, acc_d;
  logic [15:0]     res_addr_q, res_addr_d;
  logic [1:0]      res_status_q, res_status_d;

  // Table RAM port signals.
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [EntW-1:0] ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [EntW-1:0] ram_rdata;
  ffha_pkg::entry_t rd_ent;

  // The shared adder. Subtractions use the complement and a carry in, so
  // bit 16 of the sum is the "no borrow" flag of a 16-bit subtract.
  logic [17:0] alu_a;
  logic [17:0] alu_b;
  logic        alu_cin;
  logic [17:0] alu_sum;

  logic             is_alloc;
  logic             scan_more;
  logic             hit;
  logic             shift_more;
  logic             app_fail;
  logic [CntW+5:0]  cnt_ext;

  ffha_ram #(
    .Width (EntW),
    .Depth (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ent   = ffha_pkg::entry_t'(ram_rdata);
  assign is_alloc = (req_q.req_type == ffha_pkg::ReqAlloc);
  assign alu_sum  = alu_a + alu_b + 18'(alu_cin);
  assign cnt_ext  = {6'b0, cnt_q};

  // Operand selection for the shared adder, one use per state.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state_q)
      S_SCAN: begin
        if (is_alloc) begin
          // Block length minus requested size.
          alu_a   = {2'b0, rd_ent.length};
          alu_b   = {2'b0, ~req_q.req_size};
          alu_cin = 1'b1;
        end else begin
          // Payload address of the row just read.
          alu_a = {2'b0, rd_ent.offset};
          alu_b = Hdr;
        end
      end
      S_TAKE: begin
        alu_a = {2'b0, ent_q.offset};
        alu_b = Hdr;
      end
      S_TEST: begin
        // Leftover minus one header.
        alu_a   = {2'b0, rest_q};
        alu_b   = {2'b0, ~Hdr[15:0]};
        alu_cin = 1'b1;
      end
      S_NEWO: begin
        alu_a = {2'b0, pay_q};
        alu_b = {2'b0, req_q.req_size};
      end
      S_APP: begin
        alu_a = {1'b0, heap_end_q};
        alu_b = Hdr;
      end
      S_APP2: begin
        alu_a = acc_q;
        alu_b = {2'b0, req_q.req_size};
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign scan_more  = (rd_idx_q < cnt_q);
  assign hit        = pv_q && (is_alloc ? (rd_ent.is_free && alu_sum[16])
                                        : (alu_sum[16:0] == {1'b0, req_q.free_addr}));
  assign shift_more = ({1'b0, j_q} > ({1'b0, hit_idx_q} + (IdxW+1)'(1)));
  assign app_fail   = (cnt_q >= CntMax) || (alu_sum > HeapLim) || (acc_q > AddrLim);

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    ent_d        = ent_q;
    out_d        = out_q;
    out_vld_d    = out_vld_q;
    cnt_d        = cnt_q;
    heap_end_d   = heap_end_q;
    rd_idx_d     = rd_idx_q;
    p_idx_d      = p_idx_q;
    pv_d         = pv_q;
    hit_idx_d    = hit_idx_q;
    j_d          = j_q;
    wj_d         = wj_q;
    rest_d       = rest_q;
    pay_d        = pay_q;
    newlen_d     = newlen_q;
    acc_d        = acc_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;

    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    ram_wdata = '0;
    ram_raddr = '0;

    // A result leaves the output register when the sink takes it.
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          rd_idx_d = '0;
          pv_d     = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next row read while checking the row that came back.
        ram_raddr = rd_idx_q[IdxW-1:0];
        pv_d      = scan_more;
        p_idx_d   = rd_idx_q[IdxW-1:0];
        if (scan_more) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        if (hit) begin
          hit_idx_d = p_idx_q;
          ent_d     = rd_ent;
          rest_d    = alu_sum[15:0];
          state_d   = is_alloc ? S_TAKE : S_FREE;
        end else if (!pv_q && !scan_more) begin
          if (is_alloc) begin
            state_d = S_APP;
          end else begin
            res_addr_d   = '0;
            res_status_d = ffha_pkg::StatusBadFree;
            state_d      = S_DONE;
          end
        end
      end

      S_FREE: begin
        ram_we       = 1'b1;
        ram_waddr    = hit_idx_q;
        ram_wdata    = {ent_q.offset, ent_q.length, 1'b1};
        res_addr_d   = '0;
        res_status_d = ffha_pkg::StatusOk;
        state_d      = S_DONE;
      end

      S_TAKE: begin
        pay_d   = alu_sum[15:0];
        state_d = S_TEST;
      end

      S_TEST: begin
        newlen_d = alu_sum[15:0];
        if (alu_sum[16] && (cnt_q < CntMax)) begin
          // Split: open a gap behind the chosen row first.
          j_d     = cnt_q[IdxW-1:0];
          pv_d    = 1'b0;
          state_d = S_SHIFT;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = hit_idx_q;
          ram_wdata    = {ent_q.offset, ent_q.length, 1'b0};
          res_addr_d   = pay_q;
          res_status_d = ffha_pkg::StatusOk;
          state_d      = S_DONE;
        end
      end

      S_SHIFT: begin
        // Move rows up by one, top first; read and write overlap.
        if (pv_q) begin
          ram_we    = 1'b1;
          ram_waddr = wj_q;
          ram_wdata = ram_rdata;
        end
        if (shift_more) begin
          ram_raddr = j_q - IdxW'(1);
          wj_d      = j_q;
          j_d       = j_q - IdxW'(1);
          pv_d      = 1'b1;
        end else begin
          pv_d = 1'b0;
          if (!pv_q) begin
            state_d = S_NEWO;
          end
        end
      end

      S_NEWO: begin
        // The leftover becomes a free row right after the chosen one.
        ram_we    = 1'b1;
        ram_waddr = hit_idx_q + IdxW'(1);
        ram_wdata = {alu_sum[15:0], newlen_q, 1'b1};
        state_d   = S_CUR;
      end

      S_CUR: begin
        ram_we       = 1'b1;
        ram_waddr    = hit_idx_q;
        ram_wdata    = {ent_q.offset, req_q.req_size, 1'b0};
        cnt_d        = cnt_q + CntW'(1);
        res_addr_d   = pay_q;
        res_status_d = ffha_pkg::StatusOk;
        state_d      = S_DONE;
      end

      S_APP: begin
        acc_d   = alu_sum;
        state_d = S_APP2;
      end

      S_APP2: begin
        if (app_fail) begin
          res_addr_d   = '0;
          res_status_d = ffha_pkg::StatusNoSpace;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = cnt_q[IdxW-1:0];
          ram_wdata    = {heap_end_q[15:0], req_q.req_size, 1'b0};
          cnt_d        = cnt_q + CntW'(1);
          heap_end_d   = alu_sum[16:0];
          res_addr_d   = acc_q[15:0];
          res_status_d = ffha_pkg::StatusOk;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d.payload_addr = res_addr_q;
          out_d.status       = res_status_q;
          out_d.block_total  = cnt_ext[5:0];
          out_vld_d          = 1'b1;
          state_d            = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= '0;
      ent_q        <= '0;
      out_q        <= '0;
      out_vld_q    <= 1'b0;
      cnt_q        <= '0;
      heap_end_q   <= '0;
      rd_idx_q     <= '0;
      p_idx_q      <= '0;
      pv_q         <= 1'b0;
      hit_idx_q    <= '0;
      j_q          <= '0;
      wj_q         <= '0;
      rest_q       <= '0;
      pay_q        <= '0;
      newlen_q     <= '0;
      acc_q        <= '0;
      res_addr_q   <= '0;
      res_status_q <= '0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      ent_q        <= ent_d;
      out_q        <= out_d;
      out_vld_q    <= out_vld_d;
      cnt_q        <= cnt_d;
      heap_end_q   <= heap_end_d;
      rd_idx_q     <= rd_idx_d;
      p_idx_q      <= p_idx_d;
      pv_q         <= pv_d;
      hit_idx_q    <= hit_idx_d;
      j_q          <= j_d;
      wj_q         <= wj_d;
      rest_q       <= rest_d;
      pay_q        <= pay_d;
      newlen_q     <= newlen_d;
      acc_q        <= acc_d;
      res_addr_q   <= res_addr_d;
      res_status_q <= res_status_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_rsp_o   = out_q;

endmodule

/* sv/ffha_checker.sv */
`include "first_fit_heap_allocator_unit_defines.svh"

module ffha_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input ffha_pkg::req_t in_req_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ffha_pkg::rsp_t out_rsp_o
);

  // The unit works on one request at a time.
  `FFHA_ASSERT_NXT(a_busy_after_transfer, in_valid_i && !in_stall_o, in_stall_o)

  // Errors never grant an address.
  `FFHA_ASSERT_IMP(a_error_addr_zero, out_valid_o && (out_rsp_o.status != ffha_pkg::StatusOk), out_rsp_o.payload_addr == 16'd0)

  `FFHA_ASSERT_IMP(a_status_known, out_valid_o, (out_rsp_o.status == ffha_pkg::StatusOk) || (out_rsp_o.status == ffha_pkg::StatusNoSpace) || (out_rsp_o.status == ffha_pkg::StatusBadFree))

  // A new result only appears at the end of a busy period.
  `FFHA_ASSERT_IMP(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

  `FFHA_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o))

endmodule

bind first_fit_heap_allocator_unit ffha_checker u_ffha_checker (.*);

/* test/tb_first_fit_heap_allocator_unit.sv */
module tb_first_fit_heap_allocator_unit;

  // Sizes of the block under test, kept at the unit's defaults.
  localparam int unsigned MAX_BLOCKS   = 32;
  localparam int unsigned HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 25;

  // Number of random requests after the directed part, and how many of the
  // last ones run with no idling on either side.
  localparam int unsigned RANDOM_REQS = 930;
  localparam int unsigned QUIET_REQS  = 100;

  // The receiver holds its stall this long once, so the result register and
  // the request in flight both back up and the unit stalls its input.
  localparam int unsigned LONG_HOLD_CYCLES = 260;
  localparam int unsigned LONG_HOLD_AT     = 300;

  // The drain at the end waits a good deal longer than the slowest request
  // takes, for stray results.
  localparam int unsigned DRAIN_CYCLES = 2 * MAX_BLOCKS + 16;

  // The scoreboard keeps its own copy of the block table and predicts the
  // result of every accepted request in acceptance order.
  class ffha_scoreboard;
    ffha_pkg::entry_t tbl[MAX_BLOCKS];
    int               blocks;
    int unsigned      heap_top;
    int unsigned      accepted;
    int unsigned      mismatches;
    ffha_pkg::rsp_t   expected_rsp[$];

    function new();
      foreach (tbl[i]) tbl[i] = '0;
      blocks     = 0;
      heap_top   = 0;
      accepted   = 0;
      mismatches = 0;
    endfunction

    function logic [15:0] payload_of(int idx);
      return 16'(int'(tbl[idx].offset) + HEADER_BYTES);
    endfunction

    // First fit over the table; a large enough leftover becomes a new free
    // row right behind the granted one, if the table has room for it.
    function ffha_pkg::rsp_t grant_alloc(logic [15:0] size);
      int unsigned    rest;
      int unsigned    start;
      ffha_pkg::rsp_t r;
      r = '0;
      for (int i = 0; i < blocks; i++) begin
        if (tbl[i].is_free && tbl[i].length >= size) begin
          rest = int'(tbl[i].length) - int'(size);
          tbl[i].is_free = 1'b0;
          if (rest >= HEADER_BYTES && blocks < MAX_BLOCKS) begin
            for (int j = blocks; j > i + 1; j--) tbl[j] = tbl[j - 1];
            tbl[i + 1].offset  = 16'(int'(tbl[i].offset) + HEADER_BYTES + int'(size));
            tbl[i + 1].length  = 16'(rest - HEADER_BYTES);
            tbl[i + 1].is_free = 1'b1;
            tbl[i].length      = size;
            blocks++;
          end
          r.payload_addr = payload_of(i);
          r.status       = ffha_pkg::StatusOk;
          r.block_total  = 6'(blocks);
          return r;
        end
      end
      // Nothing fits, so the block goes at the heap end. The payload must
      // stay inside the heap and its address must fit in 16 bits.
      start = heap_top;
      if (blocks >= MAX_BLOCKS || start + HEADER_BYTES + size > HEAP_BYTES ||
          start + HEADER_BYTES > 32'hFFFF) begin
        r.status = ffha_pkg::StatusNoSpace;
      end else begin
        tbl[blocks].offset  = 16'(start);
        tbl[blocks].length  = size;
        tbl[blocks].is_free = 1'b0;
        blocks++;
        heap_top       = start + HEADER_BYTES + size;
        r.payload_addr = 16'(start + HEADER_BYTES);
        r.status       = ffha_pkg::StatusOk;
      end
      r.block_total = 6'(blocks);
      return r;
    endfunction

    // A free of a row that is already free is still a success.
    function ffha_pkg::rsp_t release_block(logic [15:0] addr);
      ffha_pkg::rsp_t r;
      bit             found;
      r     = '0;
      found = 1'b0;
      for (int i = 0; i < blocks; i++) begin
        if (!found && int'(tbl[i].offset) + HEADER_BYTES == int'(addr)) begin
          tbl[i].is_free = 1'b1;
          found          = 1'b1;
        end
      end
      r.status      = found ? ffha_pkg::StatusOk : ffha_pkg::StatusBadFree;
      r.block_total = 6'(blocks);
      return r;
    endfunction

    function void note_request(ffha_pkg::req_t req);
      accepted++;
      if (req.req_type == ffha_pkg::ReqAlloc) expected_rsp.push_back(grant_alloc(req.req_size));
      else expected_rsp.push_back(release_block(req.free_addr));
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Prints one line per mismatch and counts it.
    task report_mismatch(string what, int unsigned got, int unsigned want);
      mismatches++;
      $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task check_result(ffha_pkg::rsp_t got);
      ffha_pkg::rsp_t want;
      if (expected_rsp.size() == 0) begin
        report_mismatch("result with no request pending", 32'(got), 0);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.payload_addr !== want.payload_addr)
        report_mismatch("payload_addr", 32'(got.payload_addr), 32'(want.payload_addr));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.block_total !== want.block_total)
        report_mismatch("block_total", 32'(got.block_total), 32'(want.block_total));
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  ffha_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_stall_i;
  ffha_pkg::rsp_t out_rsp_o;

  ffha_scoreboard sb;
  bit             quiet_phase = 1'b0;
  bit             tx_calm     = 1'b0;

  first_fit_heap_allocator_unit #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Result monitor: a transfer on the output side happens at a rising edge
  // with valid high and stall low. The stall is only changed at falling edges.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
  end

  // Offers one request and holds it until the unit takes it. A random gap
  // may come first, with the payload scrambled while valid is low.
  task automatic send_request(input ffha_pkg::req_t req);
    int unsigned gap;
    if (!quiet_phase && !tx_calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_req_i   <= ffha_pkg::req_t'({$urandom, $urandom});
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  // The field that a request type ignores still gets random bits.
  task automatic post_alloc(input logic [15:0] size);
    ffha_pkg::req_t req;
    req.req_type  = ffha_pkg::ReqAlloc;
    req.req_size  = size;
    req.free_addr = 16'($urandom);
    send_request(req);
  endtask

  task automatic post_free(input logic [15:0] addr);
    ffha_pkg::req_t req;
    req.req_type  = ffha_pkg::ReqFree;
    req.req_size  = 16'($urandom);
    req.free_addr = addr;
    send_request(req);
  endtask

  // Mostly small allocations, so the table fills through splits, and frees
  // that hit real rows (double frees included). The rest is large or full
  // range sizes, near misses and random addresses.
  function automatic ffha_pkg::req_t random_request();
    ffha_pkg::req_t req;
    int unsigned    pick;
    req.req_size  = 16'($urandom);
    req.free_addr = 16'($urandom);
    pick          = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      req.req_type = ffha_pkg::ReqAlloc;
      if (pick < 65) req.req_size = 16'($urandom_range(0, 200));
      else if (pick < 85) req.req_size = 16'($urandom_range(201, 3000));
      else if (pick < 97) req.req_size = 16'($urandom);
      else if (pick < 99) req.req_size = 16'd0;
      else req.req_size = 16'hFFFF;
    end else begin
      req.req_type = ffha_pkg::ReqFree;
      if (sb.blocks > 0 && pick < 80)
        req.free_addr = sb.payload_of($urandom_range(0, sb.blocks - 1));
      else if (sb.blocks > 0 && pick < 90)
        req.free_addr = sb.payload_of($urandom_range(0, sb.blocks - 1)) +
                        (pick[0] ? 16'd1 : 16'hFFFF);
    end
    return req;
  endfunction

  // Receiver: random stall bursts of random length in some stretches, calm
  // stretches with none, one long hold-off, and no stalls in the quiet phase.
  initial begin : receiver
    int unsigned burst;
    int unsigned cycles;
    bit          rx_calm;
    bit          long_hold_done;
    out_stall_i    = 1'b0;
    cycles         = 0;
    rx_calm        = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles % 64 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      if (rst_ni && !long_hold_done && sb.accepted >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && !rx_calm && $urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A zero-size block, then a request too large for the heap.
    post_alloc(16'd0);
    post_alloc(16'hFFFF);
    post_alloc(16'd100);
    // Free, free the same block again, then addresses that match no row.
    post_free(16'd50);
    post_free(16'd50);
    post_free(16'd51);
    post_free(16'hFFFF);
    post_free(16'h0000);
    // Split the freed block, then take the split-off rest exactly.
    post_alloc(16'd40);
    post_alloc(16'd35);
    // Leftover below one header: the whole block is granted.
    post_free(16'd115);
    post_alloc(16'd20);
    post_alloc(16'd0);
    // Fill the heap so the next payload would start at 65536, then ask for
    // a zero-size block and a one-byte block, both refused.
    post_alloc(16'(65511 - sb.heap_top - HEADER_BYTES));
    post_alloc(16'd0);
    post_alloc(16'd1);
    // Free the big block; it feeds the splits of the random part.
    post_free(16'd200);
    post_alloc(16'hFFFF);

    for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
      if (n % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      if (n == RANDOM_REQS - QUIET_REQS) quiet_phase = 1'b1;
      send_request(random_request());
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Wait for every result, then a while longer for any stray transfer.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin : watchdog
    #6000000;
    $display("simulation failed");
    $finish;
  end

endmodule
